>>> rtl/indexed_array_list_engine_defines.svh
// ---------------------------------------------------------------------------
// Indexed array list engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define INDEXED_ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define IALE_ASSERT_NOW(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("indexed array list engine: assertion failed");

// Next-cycle implication.
`define IALE_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("indexed array list engine: assertion failed");

`endif

>>> rtl/iale_pkg.sv
// ---------------------------------------------------------------------------
// Indexed array list engine package
// Item types, action and status codes, cell control and controller states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iale_pkg;

  localparam int DEPTH   = 32;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int BS_W    = CNT_W + 1;
  localparam int GRP_W   = 3;
  localparam int GROUP   = 1 << GRP_W;
  localparam int NGROUP  = DEPTH / GROUP;
  localparam int GCNT_W  = IDX_W - GRP_W;

  localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(32);

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LSRCH  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_BSRCH  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SET    = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         position;
    logic signed [WORD_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic [IDX_W-1:0]         found_index;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         entry_count;
  } out_item_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                     commit;
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         position;
    logic [CNT_W-1:0]         cnt;
    logic [IDX_W-1:0]         fidx;
    logic signed [WORD_W-1:0] operand;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_BSRCH,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

>>> rtl/iale_cell.sv
// ---------------------------------------------------------------------------
// Indexed array list cell
// Holds one list entry; shifts from a neighbor, loads, swaps and flags a key match.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iale_cell (
  input  wire                             clk,
  input  wire logic [iale_pkg::IDX_W-1:0] k,
  input  wire iale_pkg::cell_ctl_t        ctl,
  input  wire logic signed [iale_pkg::WORD_W-1:0] from_left,
  input  wire logic signed [iale_pkg::WORD_W-1:0] from_right,
  input  wire logic signed [iale_pkg::WORD_W-1:0] head,
  output logic signed [iale_pkg::WORD_W-1:0]      value,
  output logic                                    hit
);
  import iale_pkg::*;

  logic signed [WORD_W-1:0] value_next;
  logic [CNT_W-1:0]         k_ext;

  assign k_ext = CNT_W'(k);

  always_comb begin
    value_next = value;
    if (ctl.commit) begin
      case (ctl.action)
        ACT_INSERT: begin
          if (k == ctl.position) begin
            value_next = ctl.operand;
          end else if (k > ctl.position && k_ext <= ctl.cnt) begin
            value_next = from_left;
          end
        end
        ACT_DELETE: begin
          if (k >= ctl.position && (k_ext + CNT_W'(1)) < ctl.cnt) begin
            value_next = from_right;
          end
        end
        ACT_LSRCH: begin
          // The matched entry trades places with the head.
          if (k == ctl.fidx) begin
            value_next = head;
          end
          if (k == '0) begin
            value_next = ctl.operand;
          end
        end
        ACT_SET: begin
          if (k == ctl.position) begin
            value_next = ctl.operand;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    hit   <= (k_ext < ctl.cnt) && (value == ctl.operand);
  end

endmodule

`default_nettype wire

>>> rtl/indexed_array_list_engine.sv
// Steps: insert, delete, get, set and unknown actions go from acceptance to the finish
// state, which registers the result once the output is free; a linear search registers
// match flags and scans them in groups of 8; a binary search makes one probe per cycle.
// Throughput: one item at a time; the next item is accepted once the result is
// registered, even while that result still waits to be taken.
// Reset clears the length, restores the capacity limit to 32; entries are not cleared.
// ---------------------------------------------------------------------------
// Indexed array list engine
// Chain of entry cells with a sequencer for insert, delete, search, get and set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_array_list_engine_defines.svh"

module indexed_array_list_engine (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              req_valid,
  output logic                             req_ready,
  input  wire iale_pkg::in_item_t          req,
  output logic                             rsp_valid,
  input  wire                              rsp_ready,
  output iale_pkg::out_item_t              rsp,
  input  wire                              cfg_we,
  input  wire logic [iale_pkg::CNT_W-1:0]  cfg_data
);
  import iale_pkg::*;

  state_t                   state, state_next;
  in_item_t                 cur, cur_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [CNT_W-1:0]         limit;
  logic signed [BS_W-1:0]   lo, lo_next, hi, hi_next;
  logic [GCNT_W-1:0]        grp, grp_next;
  logic                     found, found_next;
  logic [IDX_W-1:0]         found_idx, found_idx_next;
  out_item_t                rsp_next;
  logic                     rsp_valid_next;

  cell_ctl_t                ctl;
  logic signed [WORD_W-1:0] vals  [DEPTH];
  logic signed [WORD_W-1:0] left_in [DEPTH];
  logic signed [WORD_W-1:0] right_in [DEPTH];
  logic [DEPTH-1:0]         hit_vec;

  logic                     rsp_free;
  logic                     accept;
  logic signed [BS_W-1:0]   mid;
  logic [IDX_W-1:0]         rd_addr;
  logic signed [WORD_W-1:0] rd_val;
  logic [GROUP-1:0]         seg;
  logic                     seg_hit;
  logic [GRP_W-1:0]         seg_off;
  logic                     ok;
  logic                     commit;

  // Cell chain.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_in[g] = '0;
    end else begin : g_mid_l
      assign left_in[g] = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in[g] = '0;
    end else begin : g_mid_r
      assign right_in[g] = vals[g+1];
    end
    iale_cell u_cell (
      .clk        (clk),
      .k          (IDX_W'(g)),
      .ctl        (ctl),
      .from_left  (left_in[g]),
      .from_right (right_in[g]),
      .head       (vals[0]),
      .value      (vals[g]),
      .hit        (hit_vec[g])
    );
  end

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  assign mid     = BS_W'((lo + hi) >>> 1);
  assign rd_addr = (state == S_BSRCH) ? mid[IDX_W-1:0] : cur.position;
  assign rd_val  = vals[rd_addr];
  assign seg     = hit_vec[grp*GROUP +: GROUP];

  always_comb begin
    seg_hit = 1'b0;
    seg_off = '0;
    for (int b = GROUP - 1; b >= 0; b--) begin
      if (seg[b]) begin
        seg_hit = 1'b1;
        seg_off = GRP_W'(b);
      end
    end
  end

  // Legality of the pending action.
  always_comb begin
    case (cur.action) inside
      ACT_INSERT: ok = (count < limit) && (count < CNT_W'(DEPTH)) &&
                       (CNT_W'(cur.position) <= count);
      ACT_DELETE, ACT_GET, ACT_SET: ok = CNT_W'(cur.position) < count;
      ACT_LSRCH, ACT_BSRCH: ok = found;
      default: ok = 1'b0;
    endcase
  end

  assign commit = (state == S_FIN) && rsp_free && ok;

  always_comb begin
    ctl.commit   = commit;
    ctl.action   = cur.action;
    ctl.position = cur.position;
    ctl.cnt      = count;
    ctl.fidx     = found_idx;
    ctl.operand  = cur.operand;
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    count_next     = count;
    lo_next        = lo;
    hi_next        = hi;
    grp_next       = grp;
    found_next     = found;
    found_idx_next = found_idx;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_next       = req;
          found_next     = 1'b0;
          found_idx_next = '0;
          lo_next        = '0;
          hi_next        = BS_W'($signed({1'b0, count})) - BS_W'(1);
          grp_next       = '0;
          case (req.action)
            ACT_LSRCH: state_next = S_MATCH;
            ACT_BSRCH: state_next = S_BSRCH;
            default:   state_next = S_FIN;
          endcase
        end
      end
      S_MATCH: begin
        // Cells register their match flags during this cycle.
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (seg_hit) begin
          found_next     = 1'b1;
          found_idx_next = {grp, seg_off};
          state_next     = S_FIN;
        end else if (grp == GCNT_W'(NGROUP - 1)) begin
          state_next = S_FIN;
        end else begin
          grp_next = grp + GCNT_W'(1);
        end
      end
      S_BSRCH: begin
        if (lo > hi) begin
          state_next = S_FIN;
        end else if (cur.operand == rd_val) begin
          found_next     = 1'b1;
          found_idx_next = mid[IDX_W-1:0];
          state_next     = S_FIN;
        end else if (cur.operand < rd_val) begin
          hi_next = mid - BS_W'(1);
        end else begin
          lo_next = mid + BS_W'(1);
        end
      end
      S_FIN: begin
        if (rsp_free) begin
          rsp_next.result_value = '0;
          rsp_next.found_index  = '0;
          rsp_next.status       = ok ? ST_DONE : ST_BAD;
          case (cur.action) inside
            ACT_INSERT: begin
              if (ok) begin
                count_next = count + CNT_W'(1);
              end
            end
            ACT_DELETE: begin
              if (ok) begin
                rsp_next.result_value = rd_val;
                count_next            = count - CNT_W'(1);
              end
            end
            ACT_LSRCH, ACT_BSRCH: begin
              rsp_next.found_index = found_idx;
              rsp_next.status      = found ? ST_DONE : ST_NOTFOUND;
            end
            ACT_GET: begin
              rsp_next.result_value = ok ? rd_val : '1;
            end
            default: ;
          endcase
          rsp_next.entry_count = count_next;
          rsp_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      limit     <= LIMIT_RST;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_we) begin
        limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    lo        <= lo_next;
    hi        <= hi_next;
    grp       <= grp_next;
    found     <= found_next;
    found_idx <= found_idx_next;
    rsp       <= rsp_next;
  end

  `IALE_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `IALE_ASSERT_NEXT(a_fin_delivers, (state == S_FIN) && rsp_free,
                    rsp_valid && (state == S_IDLE))
  `IALE_ASSERT_NOW(a_count_step, !$stable(count),
                   (count == $past(count) + CNT_W'(1)) ||
                   (count == $past(count) - CNT_W'(1)))
  `IALE_ASSERT_NOW(a_count_only_fin, !$stable(count), $past(state) == S_FIN)

endmodule

`default_nettype wire

>>> tb/sv/iale_tb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed array list engine result checker
// Tracks the list contents, the length and the capacity limit as requests are
// accepted, and compares each returned item with the oldest predicted one.
// ---------------------------------------------------------------------------

package iale_tb_pkg;

  import iale_pkg::*;

  // Action codes the block does not define; both must be refused.
  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

  localparam int PRINT_CAP = 60;

  class list_checker;
    logic signed [WORD_W-1:0] list_words [DEPTH];
    int                       length;
    int                       limit;
    out_item_t                pending_replies [$];
    int                       mismatches;
    int                       replies_seen;

    function new();
      length       = 0;
      limit        = int'(LIMIT_RST);
      mismatches   = 0;
      replies_seen = 0;
      foreach (list_words[i]) list_words[i] = '0;
    endfunction

    // Applies one request to the tracked list and returns the item it yields.
    function out_item_t apply_action(in_item_t it);
      out_item_t                r;
      int                       lim;
      int                       pos;
      int                       lo;
      int                       hi;
      int                       mid;
      bit                       hit;
      logic signed [WORD_W-1:0] held;
      r        = '0;
      r.status = ST_DONE;
      lim      = (limit < DEPTH) ? limit : DEPTH;
      pos      = int'(it.position);
      case (it.action)
        ACT_INSERT: begin
          if (length >= lim || pos > length) begin
            r.status = ST_BAD;
          end else begin
            for (int i = length; i > pos; i--) list_words[i] = list_words[i-1];
            list_words[pos] = it.operand;
            length++;
          end
        end
        ACT_DELETE: begin
          if (pos >= length) begin
            r.status = ST_BAD;
          end else begin
            r.result_value = list_words[pos];
            for (int i = pos; i + 1 < length; i++) list_words[i] = list_words[i+1];
            length--;
          end
        end
        ACT_LSRCH: begin
          r.status = ST_NOTFOUND;
          hit      = 1'b0;
          for (int i = 0; i < length && !hit; i++) begin
            if (list_words[i] == it.operand) begin
              held          = list_words[i];
              list_words[i] = list_words[0];
              list_words[0] = held;
              r.found_index = IDX_W'(i);
              r.status      = ST_DONE;
              hit           = 1'b1;
            end
          end
        end
        ACT_BSRCH: begin
          r.status = ST_NOTFOUND;
          lo       = 0;
          hi       = length - 1;
          hit      = 1'b0;
          while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            if ($signed(it.operand) == $signed(list_words[mid])) begin
              r.found_index = IDX_W'(mid);
              r.status      = ST_DONE;
              hit           = 1'b1;
            end else if ($signed(it.operand) < $signed(list_words[mid])) begin
              hi = mid - 1;
            end else begin
              lo = mid + 1;
            end
          end
        end
        ACT_GET: begin
          if (pos >= length) begin
            r.result_value = '1;
            r.status       = ST_BAD;
          end else begin
            r.result_value = list_words[pos];
          end
        end
        ACT_SET: begin
          if (pos >= length) r.status = ST_BAD;
          else list_words[pos] = it.operand;
        end
        default: begin
          r.status = ST_BAD;
        end
      endcase
      r.entry_count = CNT_W'(length);
      return r;
    endfunction

    function void note_request(in_item_t it);
      pending_replies.push_back(apply_action(it));
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_reply(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", replies_seen));
        replies_seen++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.result_value !== want.result_value)
        report($sformatf("result %0d: result_value %0d, expected %0d",
                         replies_seen, got.result_value, want.result_value));
      if (got.found_index !== want.found_index)
        report($sformatf("result %0d: found_index %0d, expected %0d",
                         replies_seen, got.found_index, want.found_index));
      if (got.status !== want.status)
        report($sformatf("result %0d: status %0d, expected %0d",
                         replies_seen, got.status, want.status));
      if (got.entry_count !== want.entry_count)
        report($sformatf("result %0d: entry_count %0d, expected %0d",
                         replies_seen, got.entry_count, want.entry_count));
      replies_seen++;
    endtask
  endclass

endpackage

>>> tb/sv/tb_indexed_array_list_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed array list engine testbench
// Directed corner requests, sorted fills for binary search and long random
// runs under several capacity limits, with random idling on both channels.
// ---------------------------------------------------------------------------

module tb_indexed_array_list_engine;

  import iale_pkg::*;
  import iale_tb_pkg::*;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  in_item_t         req       = '0;
  logic             rsp_ready = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_data  = '0;
  logic             req_ready;
  logic             rsp_valid;
  out_item_t        rsp;

  int send_idle_pct = 0;
  int stall_pct     = 0;

  list_checker sb = new();

  indexed_array_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_reply(rsp);
    rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Valid stays high into the next item unless an idle gap is drawn.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(it);
  endtask

  task automatic do_req(input logic [ACT_W-1:0] act, input int pos,
                        input logic signed [WORD_W-1:0] val);
    in_item_t it;
    it.action   = act;
    it.position = IDX_W'(pos);
    it.operand  = val;
    send_item(it);
  endtask

  // Stops sending and waits until every outstanding item has come back.
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    drain();
    cfg_data <= CNT_W'(v);
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.limit = v & ((1 << CNT_W) - 1);
  endtask

  // Most positions are drawn from zero to the current length so the boundaries are hit often.
  function automatic in_item_t make_random_request();
    in_item_t it;
    int       n;
    int       roll;
    n    = sb.length;
    roll = $urandom_range(0, 99);
    if (roll < 30)      it.action = ACT_INSERT;
    else if (roll < 45) it.action = ACT_DELETE;
    else if (roll < 60) it.action = ACT_LSRCH;
    else if (roll < 70) it.action = ACT_BSRCH;
    else if (roll < 82) it.action = ACT_GET;
    else if (roll < 96) it.action = ACT_SET;
    else                it.action = ($urandom_range(0, 1) == 1) ? ACT_RSVD7 : ACT_RSVD6;
    if ($urandom_range(0, 99) < 70)
      it.position = IDX_W'($urandom_range(0, (n < DEPTH) ? n : DEPTH - 1));
    else
      it.position = IDX_W'($urandom_range(0, DEPTH - 1));
    roll = $urandom_range(0, 99);
    if (roll < 35 && n > 0) begin
      it.operand = sb.list_words[$urandom_range(0, n - 1)];
    end else if (roll < 55) begin
      it.operand = int'($urandom_range(0, 16)) - 8;
    end else if (roll < 65) begin
      case ($urandom_range(0, 3))
        0:       it.operand = 32'sh7FFF_FFFF;
        1:       it.operand = 32'sh8000_0000;
        2:       it.operand = -1;
        default: it.operand = '0;
      endcase
    end else begin
      it.operand = $urandom;
    end
    return it;
  endfunction

  task automatic random_phase(input int n, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      send_item(make_random_request());
    end
  endtask

  // Empties the list, refills it in ascending order and probes it.
  task automatic sorted_round(input int target, input int probes);
    logic signed [WORD_W-1:0] v;
    logic signed [WORD_W-1:0] key;
    int                       idx;
    int                       roll;
    while (sb.length > 0) do_req(ACT_DELETE, $urandom_range(0, sb.length - 1), $urandom);
    v = 32'sh8000_0000 + $urandom_range(0, 1000);
    while (sb.length < target) begin
      do_req(ACT_INSERT, sb.length, v);
      v = v + $urandom_range(0, 1 << 26);
    end
    if (target == DEPTH) do_req(ACT_INSERT, $urandom_range(0, DEPTH - 1), $urandom);
    repeat (probes) begin
      idx  = $urandom_range(0, sb.length - 1);
      roll = $urandom_range(0, 99);
      if (roll < 50)      key = sb.list_words[idx];
      else if (roll < 62) key = sb.list_words[idx] + 1;
      else if (roll < 75) key = sb.list_words[idx] - 1;
      else                key = $urandom;
      if ($urandom_range(0, 4) == 0) do_req(ACT_GET, idx, key);
      else do_req(ACT_BSRCH, $urandom_range(0, DEPTH - 1), key);
    end
  endtask

  initial begin
    send_idle_pct = 30;
    stall_pct     = 46;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Empty list: every access is out of range and both searches miss; then inserts build a short list to probe.
    do_req(ACT_GET, 0, 0);
    do_req(ACT_DELETE, 0, 0);
    do_req(ACT_LSRCH, 0, 5);
    do_req(ACT_BSRCH, 0, 5);
    do_req(ACT_SET, 0, 9);
    do_req(ACT_INSERT, 1, 1);
    do_req(ACT_INSERT, 0, 32'sh7FFF_FFFF);
    do_req(ACT_INSERT, 1, 32'sh8000_0000);
    do_req(ACT_INSERT, 0, 0);
    do_req(ACT_GET, 0, 0);
    do_req(ACT_GET, 1, 0);
    do_req(ACT_GET, 2, 0);
    do_req(ACT_SET, 2, -1);
    do_req(ACT_LSRCH, 31, -1);
    do_req(ACT_LSRCH, 0, 12345);
    do_req(ACT_BSRCH, 0, 0);
    do_req(ACT_RSVD6, 31, -1);
    do_req(ACT_RSVD7, 31, 0);
    do_req(ACT_GET, 31, 0);
    do_req(ACT_DELETE, 1, 0);

    // A zero limit refuses every insert; a limit below the length holds the
    // entries but refuses inserts until deletes bring the length under it.
    write_limit(0);
    do_req(ACT_INSERT, 0, 5);
    write_limit(1);
    do_req(ACT_INSERT, 2, 6);
    do_req(ACT_DELETE, 0, 0);
    do_req(ACT_INSERT, 0, 7);
    do_req(ACT_DELETE, 0, 0);
    do_req(ACT_INSERT, 0, 32'sh0000_5A5A);

    write_limit((1 << CNT_W) - 1);
    random_phase(450, -1);
    write_limit(DEPTH);
    sorted_round(DEPTH, 80);
    sorted_round($urandom_range(1, 9), 30);

    send_idle_pct = 46;
    stall_pct     = 30;
    write_limit($urandom_range(2, 12));
    random_phase(450, -1);

    send_idle_pct = 0;
    stall_pct     = 0;
    write_limit(DEPTH);
    random_phase(300, 150);
    write_limit((sb.length > 1) ? sb.length - 1 : 1);
    random_phase(300, -1);

    drain();
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/iale_pkg.sv
rtl/iale_cell.sv
rtl/indexed_array_list_engine.sv
tb/sv/iale_tb_pkg.sv
tb/sv/tb_indexed_array_list_engine.sv
